// ===== sv/tli_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the table linear interpolator.
// Used by tli_serial_md and table_linear_interpolator; depends on nothing.
package tli_pkg;

  localparam int DW   = 32;             // Q16.16 word and operand magnitude width
  localparam int PW   = 2 * DW;         // product / dividend width
  localparam int CNTW = $clog2(PW);     // serial step counter width

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd1;
  localparam logic [1:0] ST_SHORT      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_SEG_LO,
    S_SEG_HI,
    S_PREP,
    S_CALC,
    S_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

  // Request to the serial multiply/divide unit.
  typedef struct packed {
    logic          start;
    logic [DW-1:0] mcand;
    logic [DW-1:0] mplier;
    logic [DW-1:0] divisor;
  } md_req_t;

endpackage

// ===== sv/tli_serial_md.sv =====
`timescale 1ns / 1ps
// Bit-serial unsigned multiply followed by restoring divide: (mcand*mplier)/divisor.
// Depends on tli_pkg.
module tli_serial_md (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tli_pkg::md_req_t          req,
  output logic                      done,
  output logic [tli_pkg::PW-1:0]    quo
);

  localparam logic [tli_pkg::CNTW-1:0] MUL_LAST = tli_pkg::CNTW'(tli_pkg::DW - 1);
  localparam logic [tli_pkg::CNTW-1:0] DIV_LAST = tli_pkg::CNTW'(tli_pkg::PW - 1);

  tli_pkg::md_phase_t phase_r, phase_nxt;
  logic [tli_pkg::DW-1:0]   mcand_r, mcand_nxt;
  logic [tli_pkg::DW-1:0]   div_r, div_nxt;
  logic [tli_pkg::DW-1:0]   rem_r, rem_nxt;
  logic [tli_pkg::PW-1:0]   prod_r, prod_nxt;
  logic [tli_pkg::CNTW-1:0] cnt_r, cnt_nxt;
  logic                     done_r, done_nxt;

  logic [tli_pkg::DW:0]     add_sum;
  logic [tli_pkg::DW:0]     trial;
  logic [tli_pkg::DW:0]     trial_diff;
  logic                     trial_ok;

  // One multiplier bit per cycle: the upper half accumulates, the lower half
  // shifts the multiplier out and the product low bits in.
  assign add_sum    = {1'b0, prod_r[tli_pkg::PW-1:tli_pkg::DW]}
                    + (prod_r[0] ? {1'b0, mcand_r} : '0);
  // One quotient bit per cycle; quotient bits shift into the dividend register.
  assign trial      = {rem_r, prod_r[tli_pkg::PW-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign trial_ok   = (trial >= {1'b0, div_r});

  always_comb begin
    phase_nxt = phase_r;
    mcand_nxt = mcand_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (phase_r)
      tli_pkg::MD_IDLE: begin
        if (req.start) begin
          mcand_nxt = req.mcand;
          div_nxt   = req.divisor;
          prod_nxt  = {{tli_pkg::DW{1'b0}}, req.mplier};
          cnt_nxt   = '0;
          phase_nxt = tli_pkg::MD_MUL;
        end
      end
      tli_pkg::MD_MUL: begin
        prod_nxt = {add_sum, prod_r[tli_pkg::DW-1:1]};
        cnt_nxt  = tli_pkg::CNTW'(cnt_r + 1'b1);
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          phase_nxt = tli_pkg::MD_DIV;
        end
      end
      tli_pkg::MD_DIV: begin
        prod_nxt = {prod_r[tli_pkg::PW-2:0], trial_ok};
        if (trial_ok) begin
          rem_nxt = trial_diff[tli_pkg::DW-1:0];
        end else begin
          rem_nxt = trial[tli_pkg::DW-1:0];
        end
        cnt_nxt = tli_pkg::CNTW'(cnt_r + 1'b1);
        if (cnt_r == DIV_LAST) begin
          done_nxt  = 1'b1;
          phase_nxt = tli_pkg::MD_IDLE;
        end
      end
      default: begin
        phase_nxt = tli_pkg::MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tli_pkg::MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    prod_r  <= prod_nxt;
  end

  assign done = done_r;
  assign quo  = prod_r;

endmodule

// ===== sv/table_linear_interpolator.sv =====
`timescale 1ns / 1ps
// Piecewise linear interpolator over a table of Q16.16 breakpoints.
// Depends on tli_pkg and tli_serial_md.
//
// Usage: requests enter on the in_ stream. in_tuser[0] selects a load (write one
// breakpoint x/y at entry_index) or a query (interpolate y at query_x). Every
// request yields exactly one result on the out_ stream: value and status.
// cfg_wr_en/cfg_wr_data set the number of valid breakpoints; write it only
// while the block is idle.
// Timing: a load, and a query on a table with fewer than two points, goes from
// idle straight to S_EMIT, which hands its result to the output register. Any
// other query first walks the table by linear search, one table read per cycle
// and at most point_count entries, then runs a bit-serial multiply and a
// bit-serial divide. One request is worked on at a time; the next is taken as
// soon as the current result has moved to the output register.
// Reset clears the point count and the control state; table contents are
// undefined until loaded. When the receiver stalls, the result waits in the
// output register and the block may finish one more request behind it, then
// holds in_tready low until the output register frees up.
module table_linear_interpolator #(
  parameter int MAX_POINTS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] entry_index, [39:8] point_x, [71:40] point_y, [103:72] query_x
  input  logic [103:0] in_tdata,
  // [0] op
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] value, [33:32] status, [39:34] zero
  output logic [39:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [8:0]   cfg_wr_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // Input fields
  logic                op;
  logic [7:0]          entry_index;
  logic signed [31:0]  point_x;
  logic signed [31:0]  point_y;
  logic signed [31:0]  query_x;

  assign op          = in_tuser[0];
  assign entry_index = in_tdata[7:0];
  assign point_x     = in_tdata[39:8];
  assign point_y     = in_tdata[71:40];
  assign query_x     = in_tdata[103:72];

  // Breakpoint memories
  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] y_mem [MAX_POINTS];
  logic signed [31:0] x_rd_r;
  logic signed [31:0] y_rd_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;

  tli_pkg::state_t    state_r, state_nxt;
  logic [8:0]         cfg_count_r;
  logic signed [31:0] q_r, q_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [AW-1:0]      k_r, k_nxt;
  logic [AW-1:0]      m_r, m_nxt;
  logic signed [31:0] x1_r, x1_nxt;
  logic signed [31:0] y1_r, y1_nxt;
  logic signed [32:0] dy_r, dy_nxt;
  logic signed [32:0] dq_r, dq_nxt;
  logic signed [32:0] dx_r, dx_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        res_value_r, res_value_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_value_r, out_value_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               accept;
  logic [CW-1:0]      n_in;
  logic [31:0]        dy_mag, dq_mag, dx_mag;
  logic               quo_over;
  logic [34:0]        quo_sat;
  logic signed [35:0] sum36;

  tli_pkg::md_req_t      md_req;
  logic                  md_done;
  logic [tli_pkg::PW-1:0] md_quo;

  tli_serial_md u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .done  (md_done),
    .quo   (md_quo)
  );

  assign in_tready = (state_r == tli_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign wr_addr   = AW'(entry_index);
  assign wr_en     = accept && (op == tli_pkg::OP_LOAD)
                     && (32'(entry_index) < 32'(MAX_POINTS));

  // Effective point count, capped at the table capacity.
  assign n_in = (32'(cfg_count_r) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                     : CW'(cfg_count_r);

  assign dy_mag = dy_r[32] ? 32'(-dy_r) : dy_r[31:0];
  assign dq_mag = dq_r[32] ? 32'(-dq_r) : dq_r[31:0];
  assign dx_mag = dx_r[32] ? 32'(-dx_r) : dx_r[31:0];

  assign md_req.start   = (state_r == tli_pkg::S_PREP);
  assign md_req.mcand   = dy_mag;
  assign md_req.mplier  = dq_mag;
  assign md_req.divisor = dx_mag;

  // The quotient is clamped to 2^34 before the add, which is already far
  // beyond anything that survives saturation.
  assign quo_over = (|md_quo[63:35]) || (md_quo[34] && (|md_quo[33:0]));
  assign quo_sat  = quo_over ? 35'h4_0000_0000 : md_quo[34:0];
  assign sum36    = neg_r ? ({{4{y1_r[31]}}, y1_r} - {1'b0, quo_sat})
                          : ({{4{y1_r[31]}}, y1_r} + {1'b0, quo_sat});

  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    m_nxt          = m_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    dy_nxt         = dy_r;
    dq_nxt         = dq_r;
    dx_nxt         = dx_r;
    neg_nxt        = neg_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    rd_addr        = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tli_pkg::S_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          q_nxt = query_x;
          n_nxt = n_in;
          if (op == tli_pkg::OP_LOAD) begin
            res_value_nxt  = '0;
            res_status_nxt = tli_pkg::ST_OK;
            state_nxt      = tli_pkg::S_EMIT;
          end else if (n_in < CW'(2)) begin
            res_value_nxt  = '0;
            res_status_nxt = tli_pkg::ST_SHORT;
            state_nxt      = tli_pkg::S_EMIT;
          end else begin
            state_nxt = tli_pkg::S_CHK_FIRST;
          end
        end
      end
      tli_pkg::S_CHK_FIRST: begin
        if (q_r <= x_rd_r) begin
          m_nxt     = '0;
          rd_addr   = '0;
          state_nxt = tli_pkg::S_SEG_LO;
        end else begin
          rd_addr   = AW'(n_r - CW'(1));
          state_nxt = tli_pkg::S_CHK_LAST;
        end
      end
      tli_pkg::S_CHK_LAST: begin
        if (q_r >= x_rd_r) begin
          m_nxt     = AW'(n_r - CW'(2));
          rd_addr   = AW'(n_r - CW'(2));
          state_nxt = tli_pkg::S_SEG_LO;
        end else begin
          k_nxt     = AW'(1);
          rd_addr   = AW'(1);
          state_nxt = tli_pkg::S_SCAN;
        end
      end
      tli_pkg::S_SCAN: begin
        // The last point is known to lie above the query, so the walk ends
        // there at the latest; either way the segment starts one to the left.
        if ((x_rd_r > q_r) || (CW'(k_r) == n_r - CW'(1))) begin
          m_nxt     = AW'(k_r - AW'(1));
          rd_addr   = AW'(k_r - AW'(1));
          state_nxt = tli_pkg::S_SEG_LO;
        end else begin
          k_nxt   = AW'(k_r + AW'(1));
          rd_addr = AW'(k_r + AW'(1));
        end
      end
      tli_pkg::S_SEG_LO: begin
        x1_nxt    = x_rd_r;
        y1_nxt    = y_rd_r;
        rd_addr   = AW'(m_r + AW'(1));
        state_nxt = tli_pkg::S_SEG_HI;
      end
      tli_pkg::S_SEG_HI: begin
        if (x_rd_r == x1_r) begin
          res_value_nxt  = y1_r;
          res_status_nxt = tli_pkg::ST_ZERO_WIDTH;
          state_nxt      = tli_pkg::S_EMIT;
        end else begin
          dy_nxt    = 33'(y_rd_r) - 33'(y1_r);
          dq_nxt    = 33'(q_r) - 33'(x1_r);
          dx_nxt    = 33'(x_rd_r) - 33'(x1_r);
          state_nxt = tli_pkg::S_PREP;
        end
      end
      tli_pkg::S_PREP: begin
        neg_nxt   = dy_r[32] ^ dq_r[32] ^ dx_r[32];
        state_nxt = tli_pkg::S_CALC;
      end
      tli_pkg::S_CALC: begin
        if (md_done) begin
          state_nxt = tli_pkg::S_FIN;
        end
      end
      tli_pkg::S_FIN: begin
        if (sum36[35:31] == 5'b00000 || sum36[35:31] == 5'b11111) begin
          res_value_nxt = sum36[31:0];
        end else if (sum36[35]) begin
          res_value_nxt = 32'h8000_0000;
        end else begin
          res_value_nxt = 32'h7FFF_FFFF;
        end
        res_status_nxt = tli_pkg::ST_OK;
        state_nxt      = tli_pkg::S_EMIT;
      end
      tli_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = tli_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tli_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= point_x;
      y_mem[wr_addr] <= point_y;
    end
    x_rd_r <= x_mem[rd_addr];
    y_rd_r <= y_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tli_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cfg_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
    end
    q_r          <= q_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    m_r          <= m_nxt;
    x1_r         <= x1_nxt;
    y1_r         <= y1_nxt;
    dy_r         <= dy_nxt;
    dq_r         <= dq_nxt;
    dx_r         <= dx_nxt;
    neg_r        <= neg_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_value_r};

  // The serial unit only finishes while the sequencer is waiting for it.
  a_md_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == tli_pkg::S_CALC)
    else $error("serial unit finished outside the calculation wait");

  // The linear search never walks past the last valid point.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tli_pkg::S_SCAN |-> (CW'(k_r) < n_r))
    else $error("search index beyond the point count");

  // A short-table result always carries a zero value.
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] == tli_pkg::ST_SHORT) |-> out_tdata[31:0] == 32'd0)
    else $error("short-table result with nonzero value");

  // No result is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

// ===== sim/tb_table_linear_interpolator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for table_linear_interpolator: loads, queries and point counts.
// Depends on tli_pkg and the interpolator RTL; results are predicted by a Q16.16 model kept here.
module tb_table_linear_interpolator;

  localparam int MAX_PTS = 256;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic         cfg_wr_en;
  logic [8:0]   cfg_wr_data;

  // Model state: breakpoints held sign-extended, and the point count register.
  longint     table_x [MAX_PTS];
  longint     table_y [MAX_PTS];
  logic [8:0] point_count;

  result_t pending_results[$];
  result_t oldest;
  int      fail_count = 0;
  bit      gaps_on = 1'b1;
  int      hold_cycles = 0;
  int      stall_left = 0;

  table_linear_interpolator #(
    .MAX_POINTS(MAX_PTS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: a long hold when asked for, otherwise random stall bursts.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: value %h status %0d",
               out_tdata[31:0], out_tdata[33:32]);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_tdata[31:0] !== oldest.value) begin
          $error("value mismatch: expected %h, got %h", oldest.value, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[33:32] !== oldest.status) begin
          $error("status mismatch: expected %0d, got %0d", oldest.status, out_tdata[33:32]);
          fail_count++;
        end
        if (out_tdata[39:34] !== 6'd0) begin
          $error("padding mismatch: expected %h, got %h", 6'd0, out_tdata[39:34]);
          fail_count++;
        end
      end
    end
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic result_t interpolate_at(logic [31:0] qx);
    result_t         r;
    int              n;
    int              m;
    longint          q, x1, x2, y1, y2, dy, dq, dx, sum;
    longint unsigned quo;
    bit              neg;
    r.value  = '0;
    r.status = tli_pkg::ST_OK;
    n = (point_count > MAX_PTS) ? MAX_PTS : point_count;
    if (n < 2) begin
      r.status = tli_pkg::ST_SHORT;
      return r;
    end
    q = longint'($signed(qx));
    // Outside the table the end segments are extended; inside, the segment ends at
    // the first breakpoint above the query (scanning down leaves the lowest such one).
    if (q <= table_x[0]) begin
      m = 0;
    end else if (q >= table_x[n - 1]) begin
      m = n - 2;
    end else begin
      m = n - 2;
      for (int k = n - 1; k >= 1; k--) begin
        if (table_x[k] > q) m = k - 1;
      end
    end
    x1 = table_x[m];
    x2 = table_x[m + 1];
    y1 = table_y[m];
    y2 = table_y[m + 1];
    if (x2 == x1) begin
      r.value  = y1[31:0];
      r.status = tli_pkg::ST_ZERO_WIDTH;
      return r;
    end
    dy  = y2 - y1;
    dq  = q - x1;
    dx  = x2 - x1;
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    if (dy == 0 || dq == 0) neg = 1'b0;
    quo = (magnitude(dy) * magnitude(dq)) / magnitude(dx);
    if (quo > 64'h4_0000_0000) quo = 64'h4_0000_0000;
    sum = neg ? y1 - longint'(quo) : y1 + longint'(quo);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.value = sum[31:0];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(logic op, logic [7:0] idx, logic [31:0] px, logic [31:0] py,
                              logic [31:0] qx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {qx, py, px, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == tli_pkg::OP_LOAD) begin
      table_x[idx] = longint'($signed(px));
      table_y[idx] = longint'($signed(py));
      pending_results.push_back('{value: 32'd0, status: tli_pkg::ST_OK});
    end else begin
      pending_results.push_back(interpolate_at(qx));
    end
    @(negedge clk);
  endtask

  task automatic send_load(logic [7:0] idx, logic [31:0] px, logic [31:0] py);
    send_request(tli_pkg::OP_LOAD, idx, px, py, $urandom);
  endtask

  task automatic send_query(logic [31:0] qx);
    send_request(tli_pkg::OP_QUERY, 8'($urandom), $urandom, $urandom, qx);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_point_count(logic [8:0] cnt);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cnt;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    point_count = cnt;
  endtask

  // Shape 0: ascending over the full range; 1: dense ascending; 2: unordered.
  // Ascending tables sometimes repeat the first or last x so an end segment has zero width.
  task automatic load_table(int n, int shape);
    longint      span, x, prev;
    logic [31:0] y;
    bit          dup_first, dup_last;
    span      = (n > 0) ? 64'h1_0000_0000 / n : 1;
    dup_first = ($urandom_range(0, 5) == 0);
    dup_last  = ($urandom_range(0, 5) == 0);
    x         = longint'($signed($urandom)) >>> 4;
    prev      = x;
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: x = -64'sd2147483648 + i * span + $urandom_range(0, 32'(span - 1));
        1: if (i > 0) x = x + $urandom_range(1, 32'h0002_0000);
        default: x = longint'($signed($urandom));
      endcase
      if (shape != 2 && ((i == 1 && dup_first) || (i == n - 1 && i > 0 && dup_last))) x = prev;
      y = $urandom;
      if ($urandom_range(0, 2) != 0) y = $signed(y) >>> 12;
      send_load(i[7:0], x[31:0], y);
      prev = x;
    end
  endtask

  function automatic logic [31:0] pick_query_x();
    int          n;
    int unsigned r;
    logic [31:0] anchor;
    n = (point_count > MAX_PTS) ? MAX_PTS : point_count;
    r = $urandom_range(0, 9);
    if (n == 0 || r < 2) return $urandom;
    anchor = table_x[$urandom_range(0, n - 1)][31:0];
    if (r < 4) return anchor;
    if (r == 9) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return anchor + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
  endfunction

  task automatic test_short_table();
    send_query(32'h0000_0000);
    send_load(8'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_load(8'd255, 32'h7FFF_FFFF, 32'h8000_0000);
    write_point_count(9'd1);
    send_query(32'h7FFF_FFFF);
  endtask

  // Table (-1, 2), (1, 4), (3, -2) probed below, on, between and beyond the points.
  task automatic test_segments();
    logic [31:0] probes [10];
    probes = '{32'hFFFD_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_8000,
               32'h0003_0000, 32'h0005_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000};
    send_load(8'd0, 32'hFFFF_0000, 32'h0002_0000);
    send_load(8'd1, 32'h0001_0000, 32'h0004_0000);
    send_load(8'd2, 32'h0003_0000, 32'hFFFE_0000);
    write_point_count(9'd3);
    foreach (probes[i]) send_query(probes[i]);
  endtask

  task automatic test_zero_width();
    write_point_count(9'd2);
    send_load(8'd1, 32'hFFFF_0000, 32'h0007_0000);
    send_query(32'hFFFE_0000);
    send_query(32'h0004_0000);
  endtask

  task automatic test_unordered();
    write_point_count(9'd3);
    send_load(8'd1, 32'h0005_0000, 32'h0001_0000);
    send_load(8'd2, 32'h0000_0000, 32'hFFFE_0000);
    send_query(32'h0006_0000);
    send_query(32'h0002_0000);
    send_query(32'hFFFD_0000);
  endtask

  // A one-LSB segment spanning the whole y range drives the quotient into its clamp.
  task automatic test_saturation();
    write_point_count(9'd2);
    send_load(8'd0, 32'h0000_0000, 32'h8000_0000);
    send_load(8'd1, 32'h0000_0001, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF);
    send_query(32'h8000_0000);
    send_query(32'h0000_0001);
  endtask

  task automatic test_capacity();
    load_table(MAX_PTS, 1);
    write_point_count(9'd511);
    send_query(pick_query_x());
    send_query(pick_query_x());
    write_point_count(9'd257);
    send_query(pick_query_x());
    write_point_count(9'd256);
    send_query(pick_query_x());
    send_query(32'h7FFF_FFFF);
  endtask

  // The receiver holds off while requests keep coming, so the input must stall.
  task automatic test_backpressure();
    write_point_count(9'd4);
    load_table(4, 1);
    wait_idle();
    hold_cycles = 300;
    repeat (10) begin
      if ($urandom_range(0, 2) == 0) send_load(8'($urandom_range(4, 255)), $urandom, $urandom);
      else send_query(pick_query_x());
    end
  endtask

  task automatic test_random_traffic(int item_goal);
    int sent, cnt, n, mixed, r;
    sent = 0;
    while (sent < item_goal) begin
      r = $urandom_range(0, 99);
      if (r < 4) cnt = $urandom_range(0, 1);
      else if (r < 88) cnt = $urandom_range(2, 10);
      else if (r < 97) cnt = $urandom_range(11, 48);
      else cnt = $urandom_range(200, 511);
      n = (cnt > MAX_PTS) ? MAX_PTS : cnt;
      write_point_count(cnt[8:0]);
      load_table(n, ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1) : 2);
      mixed = (n > 48) ? $urandom_range(3, 8) : $urandom_range(10, 40);
      repeat (mixed) begin
        if ($urandom_range(0, 6) == 0) send_load(8'($urandom), $urandom, $urandom);
        else send_query(pick_query_x());
      end
      sent += n + mixed;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    point_count = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_table();
    test_segments();
    test_zero_width();
    test_unordered();
    test_saturation();
    test_capacity();
    test_backpressure();
    test_random_traffic(1200);
    gaps_on = 1'b0;
    test_random_traffic(150);

    wait_idle();
    repeat (400) @(negedge clk);
    if (fail_count == 0) $display("tb_table_linear_interpolator OK");
    else $display("tb_table_linear_interpolator NOT OK");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb_table_linear_interpolator NOT OK");
    $finish;
  end

endmodule
